// ===== src/odq_pkg.sv =====
// ----------------------------------------------------------------------------
// odq_pkg: shared definitions for the ordered-dither color quantizer
// Format codes, register indexes, Bayer and offset tables, channel reduction
// functions and the structs passed between the pipeline and the quantizer.
// ----------------------------------------------------------------------------
package odq_pkg;

  // Channel and field widths.
  localparam int CHAN_W      = 8;
  localparam int PHASE_W     = 2;
  localparam int FMT_W       = 3;
  localparam int OFF_W       = 8;
  localparam int RED_OUT_W   = 6;
  localparam int GREEN_OUT_W = 7;
  localparam int BLUE_OUT_W  = 6;
  localparam int ALPHA_OUT_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Pixel format codes.
  localparam logic [FMT_W-1:0] FMT_RGB565      = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB555      = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB444      = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB676      = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA4444    = 3'd4;
  localparam logic [FMT_W-1:0] FMT_RGBA5551    = 3'd5;
  localparam logic [FMT_W-1:0] FMT_RGBA5551_NA = 3'd6;
  localparam logic [FMT_W-1:0] FMT_UNUSED      = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DITHER_ENABLE = 2'd1;

  // 4x4 Bayer matrix, indexed by {row_phase, column_phase}.
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd12, 4'd2,  4'd14,
    4'd8,  4'd4,  4'd10, 4'd6,
    4'd3,  4'd15, 4'd1,  4'd13,
    4'd11, 4'd7,  4'd9,  4'd5
  };

  // Dither offsets by Bayer entry, one table per target channel depth.
  localparam logic signed [OFF_W-1:0] OFFSET_1BIT [16] = '{
    -8'sd120, -8'sd104, -8'sd88, -8'sd72, -8'sd56, -8'sd40, -8'sd24, -8'sd8,
     8'sd8,    8'sd24,   8'sd40,  8'sd56,  8'sd72,  8'sd88,  8'sd104, 8'sd120
  };
  localparam logic signed [OFF_W-1:0] OFFSET_4BIT [16] = '{
    -8'sd8, -8'sd7, -8'sd6, -8'sd5, -8'sd4, -8'sd3, -8'sd2, -8'sd1,
     8'sd1,  8'sd2,  8'sd3,  8'sd4,  8'sd5,  8'sd6,  8'sd7,  8'sd8
  };
  localparam logic signed [OFF_W-1:0] OFFSET_5BIT [16] = '{
    -8'sd4, -8'sd3, -8'sd3, -8'sd2, -8'sd2, -8'sd1, -8'sd1, 8'sd0,
     8'sd0,  8'sd1,  8'sd1,  8'sd2,  8'sd2,  8'sd3,  8'sd3, 8'sd4
  };
  localparam logic signed [OFF_W-1:0] OFFSET_6BIT [16] = '{
    -8'sd2, -8'sd2, -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd0, 8'sd0,
     8'sd0,  8'sd0,  8'sd1,  8'sd1,  8'sd1,  8'sd1, 8'sd2, 8'sd2
  };

  // Reciprocal of 34 for the 4-bit reduction: floor(x * 241 / 8192) equals
  // floor(x / 34) for every odd x up to 527.
  localparam int RECIP34_W     = 8;
  localparam int RECIP34_SHIFT = 13;
  localparam logic [RECIP34_W-1:0] RECIP34 = 8'd241;

  // Four clamped channel values of one pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } chan_t;

  // Reduced result fields of one pixel.
  typedef struct packed {
    logic [RED_OUT_W-1:0]   red;
    logic [GREEN_OUT_W-1:0] green;
    logic [BLUE_OUT_W-1:0]  blue;
    logic [ALPHA_OUT_W-1:0] alpha;
  } result_t;

  // Reduce to 7 bits: (i - (i >> 7)) >> 1.
  function automatic logic [6:0] to7(input logic [CHAN_W-1:0] i);
    logic [CHAN_W-1:0] t;
    t = i - {7'd0, i[7]};
    return t[7:1];
  endfunction

  // Reduce to 6 bits: (i - (i >> 6) + 1) >> 2. The sum never exceeds 253.
  function automatic logic [5:0] to6(input logic [CHAN_W-1:0] i);
    logic [CHAN_W-1:0] t;
    t = i - {6'd0, i[7:6]} + 8'd1;
    return t[7:2];
  endfunction

  // Reduce to 5 bits: (i - (i >> 5) + 3) >> 3. The sum never exceeds 251.
  function automatic logic [4:0] to5(input logic [CHAN_W-1:0] i);
    logic [CHAN_W-1:0] t;
    t = i - {5'd0, i[7:5]} + 8'd3;
    return t[7:3];
  endfunction

  // Reduce to 4 bits: ((2i + 17) * 15) / 510, which is (2i + 17) / 34.
  function automatic logic [3:0] to4(input logic [CHAN_W-1:0] i);
    logic [9:0]  x;
    logic [16:0] p;
    x = {1'b0, i, 1'b1} + 10'd16;
    p = {7'd0, x} * {9'd0, RECIP34};
    return p[16:RECIP34_SHIFT];
  endfunction

  // Add a signed offset and clamp the sum to 0..255.
  function automatic logic [CHAN_W-1:0] add_clamp(input logic [CHAN_W-1:0] v,
                                                  input logic signed [OFF_W-1:0] off);
    logic [CHAN_W+1:0] s;
    s = {2'b00, v} + {{2{off[OFF_W-1]}}, off};
    if (s[CHAN_W+1]) begin
      return '0;
    end else if (s[CHAN_W]) begin
      return '1;
    end
    return s[CHAN_W-1:0];
  endfunction

endpackage

// ===== src/odq_if.sv =====
// ----------------------------------------------------------------------------
// odq_if: stream channels of the ordered-dither color quantizer
// Pixel input channel, result output channel and configuration write channel,
// each with valid and ready and a source and a sink modport.
// ----------------------------------------------------------------------------

// Pixel input channel: one word is one RGBA pixel and its screen phase.
interface odq_pixel_if;
  import odq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;
  logic [CHAN_W-1:0]  alpha_in;
  logic [PHASE_W-1:0] column_phase;
  logic [PHASE_W-1:0] row_phase;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, output column_phase, output row_phase,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, input column_phase, input row_phase,
                  output ready);
endinterface

// Result output channel: one word is one reduced pixel.
interface odq_result_if;
  import odq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RED_OUT_W-1:0]   red_out;
  logic [GREEN_OUT_W-1:0] green_out;
  logic [BLUE_OUT_W-1:0]  blue_out;
  logic [ALPHA_OUT_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// Configuration write channel: one word writes one register.
interface odq_cfg_if;
  import odq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/odq_quantize.sv =====
// ----------------------------------------------------------------------------
// odq_quantize: per-format channel reduction
// Reduces four clamped 8-bit channels to the bit depths of the selected
// pixel format. Pure combinational logic that feeds the output register.
// ----------------------------------------------------------------------------
module odq_quantize (
  input  logic [odq_pkg::FMT_W-1:0] fmt,
  input  odq_pkg::chan_t            chan,
  output odq_pkg::result_t          res
);
  import odq_pkg::*;

  // Select the reductions of each channel by format; alpha is zero for RGB.
  always_comb begin
    res = '0;
    case (fmt)
      FMT_RGB565: begin
        res.red   = {1'b0, to5(chan.red)};
        res.green = {1'b0, to6(chan.green)};
        res.blue  = {1'b0, to5(chan.blue)};
      end
      FMT_RGB555: begin
        res.red   = {1'b0, to5(chan.red)};
        res.green = {2'b0, to5(chan.green)};
        res.blue  = {1'b0, to5(chan.blue)};
      end
      FMT_RGB444: begin
        res.red   = {2'b0, to4(chan.red)};
        res.green = {3'b0, to4(chan.green)};
        res.blue  = {2'b0, to4(chan.blue)};
      end
      FMT_RGB676: begin
        res.red   = to6(chan.red);
        res.green = to7(chan.green);
        res.blue  = to6(chan.blue);
      end
      FMT_RGBA4444: begin
        res.red   = {2'b0, to4(chan.red)};
        res.green = {3'b0, to4(chan.green)};
        res.blue  = {2'b0, to4(chan.blue)};
        res.alpha = to4(chan.alpha);
      end
      FMT_RGBA5551, FMT_RGBA5551_NA: begin
        res.red   = {1'b0, to5(chan.red)};
        res.green = {2'b0, to5(chan.green)};
        res.blue  = {1'b0, to5(chan.blue)};
        res.alpha = {3'b0, chan.alpha[CHAN_W-1]};
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== src/ordered_dither_color_quantizer_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_color_quantizer_unit: Bayer 4x4 dither and color reduction
// Three-stage pixel pipeline that reduces RGBA8888 pixels to 565, 555, 444,
// 676, 4444 or 5551 formats, with optional ordered dither for 565, 4444 and 5551.
// ----------------------------------------------------------------------------
// The unit takes one pixel word per clock while the output side does not
// stall and returns one result word per pixel, in order. Stage one looks up
// the Bayer entry and the dither offsets, stage two adds and clamps, stage
// three reduces each channel into the output register. Each stage has its own
// valid bit and holds its word while the stage after it is full, so bubbles
// close up and a stall drops nothing. The format and dither registers are
// sampled when a pixel is taken and must be written only while the pipeline
// is empty; the configuration channel is always ready. Format code seven
// returns an all-zero result.
module ordered_dither_color_quantizer_unit (
  input logic         clk,
  input logic         rst,
  odq_cfg_if.sink     cfg,
  odq_pixel_if.sink   pixel,
  odq_result_if.source result
);
  import odq_pkg::*;

  // Configuration registers.
  logic [FMT_W-1:0] pixel_format;
  logic             dither_enable;

  // Stage one: inputs and selected offsets.
  logic                    valid1;
  chan_t                   chan1;
  logic signed [OFF_W-1:0] off_red1;
  logic signed [OFF_W-1:0] off_green1;
  logic signed [OFF_W-1:0] off_blue1;
  logic signed [OFF_W-1:0] off_alpha1;
  logic [FMT_W-1:0]        fmt1;

  // Stage two: clamped channels.
  logic             valid2;
  chan_t            chan2;
  logic [FMT_W-1:0] fmt2;

  // Stage three: output register.
  logic    valid3;
  result_t res3;

  // Offset selection and stage readiness.
  logic [3:0]              bayer_entry;
  logic signed [OFF_W-1:0] off_red_next;
  logic signed [OFF_W-1:0] off_green_next;
  logic signed [OFF_W-1:0] off_blue_next;
  logic signed [OFF_W-1:0] off_alpha_next;
  chan_t                   chan2_next;
  result_t                 res3_next;
  logic                    ready1;
  logic                    ready2;
  logic                    ready3;

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= FMT_RGB565;
      dither_enable <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PIXEL_FORMAT) begin
        pixel_format <= cfg.data[FMT_W-1:0];
      end else if (cfg.index == REG_DITHER_ENABLE) begin
        dither_enable <= cfg.data[0];
      end
    end
  end

  // A stage takes a new word when it is empty or its word moves on.
  assign ready3      = !valid3 || result.ready;
  assign ready2      = !valid2 || ready3;
  assign ready1      = !valid1 || ready2;
  assign pixel.ready = ready1;

  // Bayer entry and per-channel offset for the current format.
  assign bayer_entry = BAYER[{pixel.row_phase, pixel.column_phase}];

  always_comb begin
    off_red_next   = '0;
    off_green_next = '0;
    off_blue_next  = '0;
    off_alpha_next = '0;
    if (dither_enable) begin
      case (pixel_format)
        FMT_RGB565: begin
          off_red_next   = OFFSET_5BIT[bayer_entry];
          off_green_next = OFFSET_6BIT[bayer_entry];
          off_blue_next  = OFFSET_5BIT[bayer_entry];
        end
        FMT_RGBA4444: begin
          off_red_next   = OFFSET_4BIT[bayer_entry];
          off_green_next = OFFSET_4BIT[bayer_entry];
          off_blue_next  = OFFSET_4BIT[bayer_entry];
          off_alpha_next = OFFSET_4BIT[bayer_entry];
        end
        FMT_RGBA5551: begin
          off_red_next   = OFFSET_5BIT[bayer_entry];
          off_green_next = OFFSET_5BIT[bayer_entry];
          off_blue_next  = OFFSET_5BIT[bayer_entry];
          off_alpha_next = OFFSET_1BIT[bayer_entry];
        end
        FMT_RGBA5551_NA: begin
          off_red_next   = OFFSET_5BIT[bayer_entry];
          off_green_next = OFFSET_5BIT[bayer_entry];
          off_blue_next  = OFFSET_5BIT[bayer_entry];
        end
        default: begin
          off_red_next = '0;
        end
      endcase
    end
  end

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && pixel.valid) begin
      chan1.red   <= pixel.red_in;
      chan1.green <= pixel.green_in;
      chan1.blue  <= pixel.blue_in;
      chan1.alpha <= pixel.alpha_in;
      off_red1    <= off_red_next;
      off_green1  <= off_green_next;
      off_blue1   <= off_blue_next;
      off_alpha1  <= off_alpha_next;
      fmt1        <= pixel_format;
    end
  end

  // Stage two: add the offsets and clamp to the 8-bit range.
  always_comb begin
    chan2_next.red   = add_clamp(chan1.red, off_red1);
    chan2_next.green = add_clamp(chan1.green, off_green1);
    chan2_next.blue  = add_clamp(chan1.blue, off_blue1);
    chan2_next.alpha = add_clamp(chan1.alpha, off_alpha1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && valid1) begin
      chan2 <= chan2_next;
      fmt2  <= fmt1;
    end
  end

  // Stage three: reduce each channel into the output register.
  odq_quantize u_quantize (
    .fmt  (fmt2),
    .chan (chan2),
    .res  (res3_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (ready3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && valid2) begin
      res3 <= res3_next;
    end
  end

  // Result channel.
  assign result.valid     = valid3;
  assign result.red_out   = res3.red;
  assign result.green_out = res3.green;
  assign result.blue_out  = res3.blue;
  assign result.alpha_out = res3.alpha;

`ifndef ASSERT_OFF
  // A taken pixel always lands in stage one.
  a_take_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> valid1)
    else $error("taken pixel did not reach stage one");

  // A word in stage two that cannot move keeps stage three full.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid2 && !ready2) |-> (valid3 && !result.ready))
    else $error("stage two stalled while stage three could move");

  // The unused format code gives an all-zero result.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (ready3 && valid2 && fmt2 == FMT_UNUSED) |=> (res3 == '0))
    else $error("unused format produced a nonzero result");

  // RGB formats return zero alpha.
  a_rgb_no_alpha: assert property (@(posedge clk) disable iff (rst)
    (ready3 && valid2 && (fmt2 == FMT_RGB565 || fmt2 == FMT_RGB555 ||
                          fmt2 == FMT_RGB444 || fmt2 == FMT_RGB676))
    |=> (res3.alpha == '0))
    else $error("RGB format produced nonzero alpha");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ordered-dither color quantizer
// A planned list of register writes, pixel words and drain points feeds a
// clocked driver. Every accepted pixel is quantized by a local predictor under
// the bench's copy of the format and dither registers. A clocked monitor
// compares each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import odq_pkg::*;

  // Run shape.
  localparam int RANDOM_ITEMS    = 850;
  localparam int IDLE_PERCENT    = 11;
  localparam int QUIET_FIRST     = 300;
  localparam int QUIET_LAST      = 450;
  localparam int HOLD_AT_RESULT  = 600;
  localparam int HOLD_CYCLES     = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 10;

  // Register indexes that decode to nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // Bayer rank by {row_phase, column_phase}.
  localparam int BAYER_RANK [16] = '{
    0,  12, 2,  14,
    8,  4,  10, 6,
    3,  15, 1,  13,
    11, 7,  9,  5
  };

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [PHASE_W-1:0] col;
    logic [PHASE_W-1:0] row;
  } pixel_word_t;

  typedef enum {OP_PIXEL, OP_REG_WRITE, OP_DRAIN} plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    pixel_word_t            pixel;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } plan_step_t;

  logic clk;
  logic rst;

  odq_pixel_if  pixel_ch ();
  odq_result_if result_ch ();
  odq_cfg_if    cfg_ch ();

  ordered_dither_color_quantizer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixel  (pixel_ch),
    .result (result_ch)
  );

  plan_step_t       stream_plan [$];
  result_t          quantized_due [$];
  logic [FMT_W-1:0] format_copy;
  logic             dither_copy;
  int               pixels_accepted;
  int               results_checked;
  int               error_count;
  int               quiet_cycles;
  logic             hold_active;
  logic             hold_done;
  int               hold_left;

  // Signed Bayer offset for a channel of the given depth, rounded half away
  // from zero: round((2B - 15) / 32 * 255 / (2^depth - 1)).
  function automatic int dither_offset(int rank, int depth);
    int den;
    int num;
    int mag;
    int q;
    den = 32 * ((1 << depth) - 1);
    num = (2 * rank - 15) * 255;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic int clamp_byte(int s);
    if (s < 0) begin
      return 0;
    end else if (s > 255) begin
      return 255;
    end
    return s;
  endfunction

  // Round-to-nearest reduction of an 8-bit value to the given depth.
  function automatic int reduce_channel(int i, int depth);
    case (depth)
      7: return (i - (i >> 7)) >> 1;
      6: return (i - (i >> 6) + 1) >> 2;
      5: return (i - (i >> 5) + 3) >> 3;
      4: return ((2 * i + 17) * 15) / 510;
      default: return i >> 7;
    endcase
  endfunction

  // Expected result word for one pixel under the given register settings.
  function automatic result_t quantize_pixel(pixel_word_t px, logic [FMT_W-1:0] fmt,
                                             logic dith);
    int rank;
    int r;
    int g;
    int b;
    int a;
    result_t q;
    rank = BAYER_RANK[{px.row, px.col}];
    r = px.red;
    g = px.green;
    b = px.blue;
    a = px.alpha;
    q = '0;
    case (fmt)
      FMT_RGB565: begin
        if (dith) begin
          r = clamp_byte(r + dither_offset(rank, 5));
          g = clamp_byte(g + dither_offset(rank, 6));
          b = clamp_byte(b + dither_offset(rank, 5));
        end
        q.red   = RED_OUT_W'(reduce_channel(r, 5));
        q.green = GREEN_OUT_W'(reduce_channel(g, 6));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 5));
      end
      FMT_RGB555: begin
        q.red   = RED_OUT_W'(reduce_channel(r, 5));
        q.green = GREEN_OUT_W'(reduce_channel(g, 5));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 5));
      end
      FMT_RGB444: begin
        q.red   = RED_OUT_W'(reduce_channel(r, 4));
        q.green = GREEN_OUT_W'(reduce_channel(g, 4));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 4));
      end
      FMT_RGB676: begin
        q.red   = RED_OUT_W'(reduce_channel(r, 6));
        q.green = GREEN_OUT_W'(reduce_channel(g, 7));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 6));
      end
      FMT_RGBA4444: begin
        if (dith) begin
          r = clamp_byte(r + dither_offset(rank, 4));
          g = clamp_byte(g + dither_offset(rank, 4));
          b = clamp_byte(b + dither_offset(rank, 4));
          a = clamp_byte(a + dither_offset(rank, 4));
        end
        q.red   = RED_OUT_W'(reduce_channel(r, 4));
        q.green = GREEN_OUT_W'(reduce_channel(g, 4));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 4));
        q.alpha = ALPHA_OUT_W'(reduce_channel(a, 4));
      end
      FMT_RGBA5551, FMT_RGBA5551_NA: begin
        if (dith) begin
          r = clamp_byte(r + dither_offset(rank, 5));
          g = clamp_byte(g + dither_offset(rank, 5));
          b = clamp_byte(b + dither_offset(rank, 5));
          if (fmt == FMT_RGBA5551) begin
            a = clamp_byte(a + dither_offset(rank, 1));
          end
        end
        q.red   = RED_OUT_W'(reduce_channel(r, 5));
        q.green = GREEN_OUT_W'(reduce_channel(g, 5));
        q.blue  = BLUE_OUT_W'(reduce_channel(b, 5));
        q.alpha = ALPHA_OUT_W'(reduce_channel(a, 1));
      end
      default: ;
    endcase
    return q;
  endfunction

  // Channel values lean toward both ends so that clamping is exercised.
  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(9))
      0, 1: return CHAN_W'($urandom_range(8));
      2, 3: return CHAN_W'($urandom_range(255, 247));
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t px;
    px.red   = random_channel();
    px.green = random_channel();
    px.blue  = random_channel();
    px.alpha = random_channel();
    px.col   = PHASE_W'($urandom_range(3));
    px.row   = PHASE_W'($urandom_range(3));
    return px;
  endfunction

  task automatic plan_reg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    plan_step_t s;
    s.kind  = OP_REG_WRITE;
    s.pixel = '0;
    s.index = index;
    s.data  = data;
    stream_plan.push_back(s);
  endtask

  task automatic plan_pixel(pixel_word_t px);
    plan_step_t s;
    s.kind  = OP_PIXEL;
    s.pixel = px;
    s.index = '0;
    s.data  = '0;
    stream_plan.push_back(s);
  endtask

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Driver: takes the plan in order. Register writes and drain points wait
  // until every pixel taken so far has returned its result word.
  always @(posedge clk) begin : plan_driver
    logic        pix_taken;
    logic        cfg_taken;
    logic        settled;
    logic        next_pix_valid;
    logic        next_cfg_valid;
    logic        sender_quiet;
    pixel_word_t taken_px;
    plan_step_t  step;
    if (rst) begin
      pixel_ch.valid <= 1'b0;
      cfg_ch.valid   <= 1'b0;
      format_copy     = FMT_RGB565;
      dither_copy     = 1'b0;
      pixels_accepted <= 0;
    end else begin
      pix_taken = pixel_ch.valid && pixel_ch.ready;
      cfg_taken = cfg_ch.valid && cfg_ch.ready;

      // Predict the result of the pixel word taken at this edge.
      if (pix_taken) begin
        taken_px.red   = pixel_ch.red_in;
        taken_px.green = pixel_ch.green_in;
        taken_px.blue  = pixel_ch.blue_in;
        taken_px.alpha = pixel_ch.alpha_in;
        taken_px.col   = pixel_ch.column_phase;
        taken_px.row   = pixel_ch.row_phase;
        quantized_due.push_back(quantize_pixel(taken_px, format_copy, dither_copy));
        pixels_accepted <= pixels_accepted + 1;
      end

      // Track the register write taken at this edge.
      if (cfg_taken) begin
        if (cfg_ch.index == REG_PIXEL_FORMAT) begin
          format_copy = cfg_ch.data[FMT_W-1:0];
        end else if (cfg_ch.index == REG_DITHER_ENABLE) begin
          dither_copy = cfg_ch.data[0];
        end
      end

      settled = (pixels_accepted == results_checked) && !pix_taken;
      sender_quiet = (pixels_accepted >= QUIET_FIRST) && (pixels_accepted < QUIET_LAST);
      next_pix_valid = pixel_ch.valid && !pix_taken;
      next_cfg_valid = cfg_ch.valid && !cfg_taken;

      // Offer the next planned word once both channels are free.
      if (!next_pix_valid && !next_cfg_valid && stream_plan.size() != 0) begin
        step = stream_plan[0];
        case (step.kind)
          OP_PIXEL: begin
            if (sender_quiet || $urandom_range(99) >= IDLE_PERCENT) begin
              void'(stream_plan.pop_front());
              pixel_ch.red_in       <= step.pixel.red;
              pixel_ch.green_in     <= step.pixel.green;
              pixel_ch.blue_in      <= step.pixel.blue;
              pixel_ch.alpha_in     <= step.pixel.alpha;
              pixel_ch.column_phase <= step.pixel.col;
              pixel_ch.row_phase    <= step.pixel.row;
              next_pix_valid = 1'b1;
            end
          end
          OP_REG_WRITE: begin
            if (settled) begin
              void'(stream_plan.pop_front());
              cfg_ch.index   <= step.index;
              cfg_ch.data    <= step.data;
              next_cfg_valid = 1'b1;
            end
          end
          default: begin
            if (settled) begin
              void'(stream_plan.pop_front());
            end
          end
        endcase
      end

      pixel_ch.valid <= next_pix_valid;
      cfg_ch.valid   <= next_cfg_valid;
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    logic    receiver_quiet;
    if (rst) begin
      result_ch.ready <= 1'b0;
      results_checked <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (quantized_due.size() == 0) begin
          $error("result word with no prediction waiting");
          error_count++;
        end else begin
          want = quantized_due.pop_front();
          if (result_ch.red_out !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, result_ch.red_out);
            error_count++;
          end
          if (result_ch.green_out !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, result_ch.green_out);
            error_count++;
          end
          if (result_ch.blue_out !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, result_ch.blue_out);
            error_count++;
          end
          if (result_ch.alpha_out !== want.alpha) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha, result_ch.alpha_out);
            error_count++;
          end
        end
        results_checked <= results_checked + 1;
      end
      receiver_quiet = (results_checked >= QUIET_FIRST) && (results_checked < QUIET_LAST);
      result_ch.ready <= !hold_active &&
                         (receiver_quiet || $urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // One long receiver hold-off so the pipeline fills and stalls its input.
  always @(posedge clk) begin : receiver_hold
    if (rst) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_left   <= 0;
    end else if (hold_active) begin
      if (hold_left == 1) begin
        hold_active <= 1'b0;
      end
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_checked >= HOLD_AT_RESULT) begin
      hold_active <= 1'b1;
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin : stall_watchdog
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Plan the stimulus, run reset, and wait for the stream to drain.
  initial begin : stimulus_plan
    pixel_word_t px;
    plan_step_t  drain;
    int          planned;
    int          phase;
    int          count;
    logic [FMT_W-1:0] fmt;

    clk = 1'b0;
    rst = 1'b1;
    error_count  = 0;
    quiet_cycles = 0;
    pixel_ch.valid        = 1'b0;
    pixel_ch.red_in       = '0;
    pixel_ch.green_in     = '0;
    pixel_ch.blue_in      = '0;
    pixel_ch.alpha_in     = '0;
    pixel_ch.column_phase = '0;
    pixel_ch.row_phase    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    result_ch.ready       = 1'b0;

    // Directed part: every format code with dither on, each with a black
    // pixel on the most negative offset, a white pixel on the most positive
    // offset, and a mixed pixel. Formats without dither show that the enable
    // has no effect there, and the unused code must return all zeros.
    plan_reg_write(REG_DITHER_ENABLE, 8'h01);
    for (int f = 0; f < 8; f++) begin
      plan_reg_write(REG_PIXEL_FORMAT, f[CFG_DATA_W-1:0]);
      if (f == FMT_RGBA5551_NA) begin
        // Writes to the spare indexes must leave both registers alone.
        plan_reg_write(REG_SPARE_2, 8'hFF);
        plan_reg_write(REG_SPARE_3, 8'h00);
      end
      plan_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00, col: 2'd0, row: 2'd0});
      plan_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF, col: 2'd1, row: 2'd2});
      plan_pixel('{red: 8'h80, green: 8'h7F, blue: 8'h01, alpha: 8'hFE, col: 2'd3, row: 2'd3});
    end

    // Random part, in phases. The first sixteen phases walk every format
    // code with dither off and then on; later ones pick settings at random.
    // Unused data bits are random so every bit of the write data toggles.
    planned = 0;
    phase = 0;
    while (planned < RANDOM_ITEMS) begin
      if (phase < 16) begin
        fmt = FMT_W'(phase % 8);
        plan_reg_write(REG_PIXEL_FORMAT, {5'($urandom_range(31)), fmt});
        plan_reg_write(REG_DITHER_ENABLE, {7'($urandom_range(127)), (phase >= 8)});
      end else begin
        plan_reg_write(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(255)));
        plan_reg_write(REG_DITHER_ENABLE, CFG_DATA_W'($urandom_range(255)));
      end
      if ($urandom_range(3) == 0) begin
        plan_reg_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                       CFG_DATA_W'($urandom_range(255)));
      end
      count = $urandom_range(70, 30);
      for (int k = 0; k < count; k++) begin
        // Midway through one phase the sender waits for every result.
        if (phase == 5 && k == count / 2) begin
          drain.kind  = OP_DRAIN;
          drain.pixel = '0;
          drain.index = '0;
          drain.data  = '0;
          stream_plan.push_back(drain);
        end
        px = random_pixel();
        plan_pixel(px);
      end
      planned += count;
      phase++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for the plan to run out and every prediction to be met.
    do begin
      @(negedge clk);
    end while (stream_plan.size() != 0 || pixel_ch.valid || cfg_ch.valid ||
               quantized_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (quantized_due.size() != 0) begin
      $error("%0d predicted result words never arrived", quantized_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/odq_pkg.sv
src/odq_if.sv
src/odq_quantize.sv
src/ordered_dither_color_quantizer_unit.sv
dv/tb.sv
